>>> rtl/scf_pkg.sv
// Shared constants, types and control structs for the strided convolution filter-sum block.
// Used by every module in rtl/; depends on nothing.
package scf_pkg;

  // Design limits.
  localparam int MAX_FILTERS = 8;
  localparam int MAX_KERNEL  = 7;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_STRIDE  = 4;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 40;
  localparam int OUT_POS_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Derived widths.
  localparam int TAPS      = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KROW_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KS_W      = $clog2(MAX_KERNEL + 1);
  localparam int STR_W     = $clog2(MAX_STRIDE + 1);
  localparam int FIL_W     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int FCNT_W    = $clog2(MAX_FILTERS + 1);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int POS_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIM_W     = POS_W + 1;
  localparam int TAPSUM_W  = SAMPLE_W + $clog2(MAX_FILTERS) + 1;
  localparam int PROD_W    = SAMPLE_W + TAPSUM_W;
  localparam int ROW_ACC_W = PROD_W + $clog2(MAX_KERNEL) + 1;
  localparam int TOT_W     = PROD_W + $clog2(TAPS) + 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  // Input operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAC,
    ST_RED,
    ST_FINISH
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              clear;
    logic              mac_en;
    logic              shift;
    logic [KROW_W-1:0] tap_col;
    logic [KROW_W-1:0] top_bank;
    logic [KS_W-1:0]   ksize;
  } cell_ctl_t;

  // One tap-sum update.
  typedef struct packed {
    logic                       en;
    logic [KROW_W-1:0]          row;
    logic [KROW_W-1:0]          col;
    logic signed [TAPSUM_W-1:0] value;
  } ts_wr_t;

endpackage

>>> rtl/strided_conv2d_filter_sum.sv
// Top level of the strided valid 2-D convolution summed over a filter bank.
// Depends on scf_pkg, scf_divider, scf_weight and scf_cell.
//
// One item is in work at a time. A weight load reads the weight row and writes
// it back. When a window ends on a pixel, the stride divider checks the window
// origin against the stride grid, and a window on the grid then runs a
// row-parallel multiply-accumulate in the cell chain, shifts the row sums out
// and loads the result once the output register is free. A write to filter_count
// starts a refresh of all MAX_KERNEL^2 tap sums during which no item is taken.
// A finished result waits in an output register while the next item is taken.
module strided_conv2d_filter_sum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [scf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic [2:0]                            filter_index,
  input  logic [2:0]                            tap_row,
  input  logic [2:0]                            tap_col,
  input  logic signed [scf_pkg::SAMPLE_W-1:0]   sample_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [scf_pkg::SUM_W-1:0]      conv_sum,
  output logic [scf_pkg::OUT_POS_W-1:0]         out_row,
  output logic [scf_pkg::OUT_POS_W-1:0]         out_col,
  output logic                                  frame_end
);

  localparam int DIM_W = scf_pkg::DIM_W;

  // Configuration registers.
  logic [2:0] cfg_ks, cfg_st;
  logic [3:0] cfg_fc;
  logic [6:0] cfg_w, cfg_h;
  logic [scf_pkg::KS_W-1:0]   k_eff;
  logic [scf_pkg::STR_W-1:0]  s_eff;
  logic [DIM_W-1:0]           w_eff, h_eff;
  logic [scf_pkg::FCNT_W-1:0] fc_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ks <= 3'd3;
      cfg_st <= 3'd1;
      cfg_fc <= 4'd1;
      cfg_w <= 7'd28;
      cfg_h <= 7'd28;
    end else if (cfg_write) begin
      case (cfg_index)
        scf_pkg::REG_KERNEL_SIZE:  cfg_ks <= cfg_data[2:0];
        scf_pkg::REG_STRIDE_STEP:  cfg_st <= cfg_data[2:0];
        scf_pkg::REG_FILTER_COUNT: cfg_fc <= cfg_data[3:0];
        scf_pkg::REG_IMAGE_WIDTH:  cfg_w <= cfg_data;
        scf_pkg::REG_IMAGE_HEIGHT: cfg_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register values brought into their legal ranges.
  always_comb begin
    if (cfg_ks == 3'd0) k_eff = scf_pkg::KS_W'(1);
    else if (int'(cfg_ks) > scf_pkg::MAX_KERNEL) k_eff = scf_pkg::KS_W'(scf_pkg::MAX_KERNEL);
    else k_eff = scf_pkg::KS_W'(cfg_ks);
    if (cfg_st == 3'd0) s_eff = scf_pkg::STR_W'(1);
    else if (int'(cfg_st) > scf_pkg::MAX_STRIDE) s_eff = scf_pkg::STR_W'(scf_pkg::MAX_STRIDE);
    else s_eff = scf_pkg::STR_W'(cfg_st);
    if (int'(cfg_fc) > scf_pkg::MAX_FILTERS) fc_eff = scf_pkg::FCNT_W'(scf_pkg::MAX_FILTERS);
    else fc_eff = scf_pkg::FCNT_W'(cfg_fc);
    if (cfg_w == 7'd0) w_eff = DIM_W'(1);
    else if (int'(cfg_w) > scf_pkg::MAX_WIDTH) w_eff = DIM_W'(scf_pkg::MAX_WIDTH);
    else w_eff = DIM_W'(cfg_w);
    if (cfg_h == 7'd0) h_eff = DIM_W'(1);
    else if (int'(cfg_h) > scf_pkg::MAX_HEIGHT) h_eff = DIM_W'(scf_pkg::MAX_HEIGHT);
    else h_eff = DIM_W'(cfg_h);
  end

  // Handshake and item decode.
  scf_pkg::state_t state, state_next;
  logic accept, pix_acc, load_ok, wt_busy;
  logic [scf_pkg::ROW_W-1:0]  pixel_row;
  logic [scf_pkg::COL_W-1:0]  pixel_col;
  logic [scf_pkg::KROW_W-1:0] pixel_bank;
  logic [DIM_W-1:0] r_ext, c_ext, k_ext, s_ext, top_pos, left_pos;
  logic in_frame, fits, last_win, col_wrap;
  logic [scf_pkg::KROW_W+1:0] tb_sum;

  assign accept = in_valid && in_ready;
  assign pix_acc = accept && (operation == scf_pkg::OP_PIXEL);
  assign load_ok = accept && (operation == scf_pkg::OP_LOAD)
                && (int'(filter_index) < scf_pkg::MAX_FILTERS)
                && (int'(tap_row) < scf_pkg::MAX_KERNEL)
                && (int'(tap_col) < scf_pkg::MAX_KERNEL);

  // Window geometry for the pixel at the current position.
  always_comb begin
    r_ext = DIM_W'(pixel_row);
    c_ext = DIM_W'(pixel_col);
    k_ext = DIM_W'(k_eff);
    s_ext = DIM_W'(s_eff);
    in_frame = (r_ext < h_eff) && (c_ext < w_eff);
    fits = in_frame && (r_ext + 1'b1 >= k_ext) && (c_ext + 1'b1 >= k_ext);
    top_pos = r_ext + 1'b1 - k_ext;
    left_pos = c_ext + 1'b1 - k_ext;
    last_win = (r_ext + s_ext >= h_eff) && (c_ext + s_ext >= w_eff);
    col_wrap = (c_ext + 1'b1 >= w_eff);
    tb_sum = (scf_pkg::KROW_W+2)'(pixel_bank) + (scf_pkg::KROW_W+2)'(scf_pkg::MAX_KERNEL)
           - (scf_pkg::KROW_W+2)'(k_eff) + 1'b1;
    if (tb_sum >= (scf_pkg::KROW_W+2)'(scf_pkg::MAX_KERNEL)) begin
      tb_sum = tb_sum - (scf_pkg::KROW_W+2)'(scf_pkg::MAX_KERNEL);
    end
  end

  // Raster position and line bank of the next pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_row <= '0;
      pixel_col <= '0;
      pixel_bank <= '0;
    end else if (pix_acc) begin
      if (col_wrap) begin
        pixel_col <= '0;
        if (r_ext + 1'b1 >= h_eff) begin
          pixel_row <= '0;
          pixel_bank <= '0;
        end else begin
          pixel_row <= pixel_row + 1'b1;
          if (pixel_bank == scf_pkg::KROW_W'(scf_pkg::MAX_KERNEL - 1)) pixel_bank <= '0;
          else pixel_bank <= pixel_bank + 1'b1;
        end
      end else begin
        pixel_col <= pixel_col + 1'b1;
        if (r_ext >= h_eff) begin
          pixel_row <= '0;
          pixel_bank <= '0;
        end
      end
    end
  end

  // Line buffer: one bank per kernel row, all read at the same column.
  logic signed [scf_pkg::SAMPLE_W-1:0] line_mem [scf_pkg::MAX_KERNEL][scf_pkg::MAX_WIDTH];
  logic signed [scf_pkg::SAMPLE_W-1:0] bank_data [scf_pkg::MAX_KERNEL];
  logic [scf_pkg::COL_W-1:0] rd_col;

  always_ff @(posedge clk) begin
    if (pix_acc && in_frame) line_mem[pixel_bank][pixel_col] <= sample_value;
    for (int b = 0; b < scf_pkg::MAX_KERNEL; b++) bank_data[b] <= line_mem[b][rd_col];
  end

  // Weight store and tap-sum refresh.
  scf_pkg::ts_wr_t ts_wr;

  scf_weight u_weight (
    .clk           (clk),
    .rst           (rst),
    .load_en       (load_ok),
    .load_filter   (scf_pkg::FIL_W'(filter_index)),
    .load_row      (scf_pkg::KROW_W'(tap_row)),
    .load_col      (scf_pkg::KROW_W'(tap_col)),
    .load_value    (sample_value),
    .refresh_start (cfg_write && (cfg_index == scf_pkg::REG_FILTER_COUNT)),
    .fcount        (fc_eff),
    .busy          (wt_busy),
    .ts_wr         (ts_wr)
  );

  // Stride check and output coordinates.
  logic div_start, div_done, rem_zero;
  logic [scf_pkg::POS_W-1:0] quot_top, quot_left;

  scf_divider u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_a (scf_pkg::POS_W'(top_pos)),
    .dividend_b (scf_pkg::POS_W'(left_pos)),
    .divisor    (s_eff),
    .done       (div_done),
    .quot_a     (quot_top),
    .quot_b     (quot_left),
    .rem_zero   (rem_zero)
  );

  // Sequencer for one pixel word.
  logic [scf_pkg::KS_W-1:0]   mac_cnt, red_cnt;
  logic [scf_pkg::COL_W-1:0]  left_col;
  logic [scf_pkg::KROW_W-1:0] top_bank, mac_col_d;
  logic mac_v_d, res_last, load_out;
  logic signed [scf_pkg::TOT_W-1:0] total;
  scf_pkg::cell_ctl_t ctl;

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    div_start = 1'b0;
    load_out = 1'b0;
    ctl.clear = 1'b0;
    ctl.mac_en = mac_v_d;
    ctl.shift = 1'b0;
    ctl.tap_col = mac_col_d;
    ctl.top_bank = top_bank;
    ctl.ksize = k_eff;
    rd_col = left_col + scf_pkg::COL_W'(mac_cnt);
    case (state)
      scf_pkg::ST_IDLE: begin
        in_ready = !wt_busy;
        if (pix_acc && fits) begin
          div_start = 1'b1;
          state_next = scf_pkg::ST_DIV;
        end
      end
      scf_pkg::ST_DIV: begin
        if (div_done) begin
          if (rem_zero) begin
            ctl.clear = 1'b1;
            state_next = scf_pkg::ST_MAC;
          end else begin
            state_next = scf_pkg::ST_IDLE;
          end
        end
      end
      scf_pkg::ST_MAC: begin
        if (mac_cnt == k_eff) state_next = scf_pkg::ST_RED;
      end
      scf_pkg::ST_RED: begin
        ctl.shift = 1'b1;
        if (red_cnt == k_eff - 1'b1) state_next = scf_pkg::ST_FINISH;
      end
      scf_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = scf_pkg::ST_IDLE;
        end
      end
      default: state_next = scf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scf_pkg::ST_IDLE;
      mac_v_d <= 1'b0;
    end else begin
      state <= state_next;
      mac_v_d <= (state == scf_pkg::ST_MAC) && (mac_cnt < k_eff);
    end
  end

  // Counters, window origin and the total.
  logic signed [scf_pkg::ROW_ACC_W-1:0] acc_chain [scf_pkg::MAX_KERNEL+1];

  always_ff @(posedge clk) begin
    mac_col_d <= scf_pkg::KROW_W'(mac_cnt);
    if (pix_acc) begin
      left_col <= scf_pkg::COL_W'(left_pos);
      top_bank <= scf_pkg::KROW_W'(tb_sum);
      res_last <= last_win;
    end
    if (ctl.clear) begin
      mac_cnt <= '0;
      red_cnt <= '0;
      total <= '0;
    end else begin
      if (state == scf_pkg::ST_MAC) mac_cnt <= mac_cnt + 1'b1;
      if (ctl.shift) begin
        red_cnt <= red_cnt + 1'b1;
        total <= total + scf_pkg::TOT_W'(acc_chain[0]);
      end
    end
  end

  // Chain of kernel-row cells; sums shift toward cell zero.
  assign acc_chain[scf_pkg::MAX_KERNEL] = '0;

  for (genvar u = 0; u < scf_pkg::MAX_KERNEL; u++) begin : g_cell
    scf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_row  (scf_pkg::KROW_W'(u)),
      .ctl       (ctl),
      .ts_wr     (ts_wr),
      .bank_data (bank_data),
      .acc_in    (acc_chain[u+1]),
      .acc_out   (acc_chain[u])
    );
  end

  // Output register with saturation to the result width.
  logic fits_sum;
  assign fits_sum = (&total[scf_pkg::TOT_W-1:scf_pkg::SUM_W-1])
                 || !(|total[scf_pkg::TOT_W-1:scf_pkg::SUM_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (fits_sum) conv_sum <= total[scf_pkg::SUM_W-1:0];
      else if (total[scf_pkg::TOT_W-1]) conv_sum <= {1'b1, {(scf_pkg::SUM_W-1){1'b0}}};
      else conv_sum <= {1'b0, {(scf_pkg::SUM_W-1){1'b1}}};
      out_row <= scf_pkg::OUT_POS_W'(quot_top);
      out_col <= scf_pkg::OUT_POS_W'(quot_left);
      frame_end <= res_last;
    end
  end

  // Checks on the sequencer.
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == scf_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("finished result did not reach the output register");

  a_mac_shift_apart: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mac_v_d, ctl.shift, ctl.clear}))
    else $error("cell chain got conflicting controls");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    wt_busy |-> !accept)
    else $error("word accepted while the weight store was busy");

endmodule

>>> rtl/scf_divider.sv
// Two-lane restoring divider by the stride, one quotient bit per cycle.
// Depends on scf_pkg.
module scf_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [scf_pkg::POS_W-1:0] dividend_a,
  input  logic [scf_pkg::POS_W-1:0] dividend_b,
  input  logic [scf_pkg::STR_W-1:0] divisor,
  output logic                      done,
  output logic [scf_pkg::POS_W-1:0] quot_a,
  output logic [scf_pkg::POS_W-1:0] quot_b,
  output logic                      rem_zero
);

  localparam int CNT_W = $clog2(scf_pkg::POS_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [scf_pkg::STR_W-1:0] dsr;
  logic [scf_pkg::POS_W-1:0] quot [2];
  logic [scf_pkg::STR_W-1:0] rem [2];
  logic [scf_pkg::POS_W-1:0] quot_next [2];
  logic [scf_pkg::STR_W-1:0] rem_next [2];
  logic [scf_pkg::STR_W:0]   trial [2];

  // One restoring step per lane.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem[i], quot[i][scf_pkg::POS_W-1]};
      if (trial[i] >= {1'b0, dsr}) begin
        rem_next[i] = scf_pkg::STR_W'(trial[i] - {1'b0, dsr});
        quot_next[i] = {quot[i][scf_pkg::POS_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][scf_pkg::STR_W-1:0];
        quot_next[i] = {quot[i][scf_pkg::POS_W-2:0], 1'b0};
      end
    end
  end

  // Step counter and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(scf_pkg::POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      quot[0] <= dividend_a;
      quot[1] <= dividend_b;
      rem[0] <= '0;
      rem[1] <= '0;
    end else if (busy) begin
      for (int i = 0; i < 2; i++) begin
        quot[i] <= quot_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  assign quot_a = quot[0];
  assign quot_b = quot[1];
  assign rem_zero = (rem[0] == '0) && (rem[1] == '0);

endmodule

>>> rtl/scf_weight.sv
// Weight store (one row of all filters per tap) with tap-sum refresh.
// Depends on scf_pkg; feeds tap-sum updates to the cell chain.
module scf_weight (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_en,
  input  logic [scf_pkg::FIL_W-1:0]         load_filter,
  input  logic [scf_pkg::KROW_W-1:0]        load_row,
  input  logic [scf_pkg::KROW_W-1:0]        load_col,
  input  logic signed [scf_pkg::SAMPLE_W-1:0] load_value,
  input  logic                              refresh_start,
  input  logic [scf_pkg::FCNT_W-1:0]        fcount,
  output logic                              busy,
  output scf_pkg::ts_wr_t                   ts_wr
);

  localparam int ROW_BITS = scf_pkg::MAX_FILTERS * scf_pkg::SAMPLE_W;

  logic [ROW_BITS-1:0]           mem [scf_pkg::TAPS];
  logic                          row_ok [scf_pkg::TAPS];
  logic                          sweep;
  logic [scf_pkg::KROW_W-1:0]    sw_row, sw_col;
  logic                          rd_en;
  logic [scf_pkg::KROW_W-1:0]    rd_row, rd_col;
  logic [scf_pkg::TAP_W-1:0]     rd_addr, st_addr;
  logic                          st_v, st_load;
  logic [scf_pkg::KROW_W-1:0]    st_row, st_col;
  logic [scf_pkg::FIL_W-1:0]     st_filter;
  logic signed [scf_pkg::SAMPLE_W-1:0] st_value;
  logic [ROW_BITS-1:0]           rd_data, merged;
  logic                          rd_ok;
  logic signed [scf_pkg::TAPSUM_W-1:0] lane_sum;
  logic                          sw_last;

  // Read request: a load goes first, otherwise the refresh sweep.
  always_comb begin
    rd_en = load_en || sweep;
    rd_row = load_en ? load_row : sw_row;
    rd_col = load_en ? load_col : sw_col;
    rd_addr = scf_pkg::TAP_W'(rd_row) * scf_pkg::TAP_W'(scf_pkg::MAX_KERNEL)
            + scf_pkg::TAP_W'(rd_col);
    st_addr = scf_pkg::TAP_W'(st_row) * scf_pkg::TAP_W'(scf_pkg::MAX_KERNEL)
            + scf_pkg::TAP_W'(st_col);
    sw_last = (sw_row == scf_pkg::KROW_W'(scf_pkg::MAX_KERNEL - 1))
           && (sw_col == scf_pkg::KROW_W'(scf_pkg::MAX_KERNEL - 1));
  end

  // Merge the loaded weight and sum the lanes of the filters in use.
  always_comb begin
    merged = rd_ok ? rd_data : '0;
    if (st_load) begin
      merged[st_filter*scf_pkg::SAMPLE_W +: scf_pkg::SAMPLE_W] = st_value;
    end
    lane_sum = '0;
    for (int f = 0; f < scf_pkg::MAX_FILTERS; f++) begin
      if (f < int'(fcount)) begin
        lane_sum = lane_sum + scf_pkg::TAPSUM_W'(
          $signed(merged[f*scf_pkg::SAMPLE_W +: scf_pkg::SAMPLE_W]));
      end
    end
    ts_wr.en = st_v;
    ts_wr.row = st_row;
    ts_wr.col = st_col;
    ts_wr.value = lane_sum;
  end

  // Control: stage valid, sweep counters and row valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= 1'b0;
      sweep <= 1'b0;
      sw_row <= '0;
      sw_col <= '0;
      for (int t = 0; t < scf_pkg::TAPS; t++) row_ok[t] <= 1'b0;
    end else begin
      st_v <= rd_en;
      if (st_v && st_load) row_ok[st_addr] <= 1'b1;
      if (refresh_start) begin
        sweep <= 1'b1;
        sw_row <= '0;
        sw_col <= '0;
      end else if (sweep && !load_en) begin
        if (sw_last) sweep <= 1'b0;
        if (sw_col == scf_pkg::KROW_W'(scf_pkg::MAX_KERNEL - 1)) begin
          sw_col <= '0;
          sw_row <= sw_row + 1'b1;
        end else begin
          sw_col <= sw_col + 1'b1;
        end
      end
    end
  end

  // Memory port and stage payload.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_ok <= row_ok[rd_addr];
    st_load <= load_en;
    st_row <= rd_row;
    st_col <= rd_col;
    st_filter <= load_filter;
    st_value <= load_value;
    if (st_v && st_load) mem[st_addr] <= merged;
  end

  assign busy = sweep || st_v;

endmodule

>>> rtl/scf_cell.sv
// One kernel-row cell: holds that row's tap sums, accumulates its window row,
// and shifts its partial sum to the neighbor. Depends on scf_pkg.
module scf_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [scf_pkg::KROW_W-1:0]           cell_row,
  input  scf_pkg::cell_ctl_t                   ctl,
  input  scf_pkg::ts_wr_t                      ts_wr,
  input  logic signed [scf_pkg::SAMPLE_W-1:0]  bank_data [scf_pkg::MAX_KERNEL],
  input  logic signed [scf_pkg::ROW_ACC_W-1:0] acc_in,
  output logic signed [scf_pkg::ROW_ACC_W-1:0] acc_out
);

  logic signed [scf_pkg::TAPSUM_W-1:0]  ts [scf_pkg::MAX_KERNEL];
  logic signed [scf_pkg::ROW_ACC_W-1:0] acc;
  logic [scf_pkg::KROW_W:0]             bank_sum;
  logic [scf_pkg::KROW_W-1:0]           bank_sel;
  logic signed [scf_pkg::PROD_W-1:0]    product;
  logic                                 active;

  // Pick the line bank that holds this cell's window row.
  always_comb begin
    bank_sum = {1'b0, ctl.top_bank} + {1'b0, cell_row};
    if (bank_sum >= (scf_pkg::KROW_W+1)'(scf_pkg::MAX_KERNEL)) begin
      bank_sum = bank_sum - (scf_pkg::KROW_W+1)'(scf_pkg::MAX_KERNEL);
    end
    bank_sel = bank_sum[scf_pkg::KROW_W-1:0];
    product = bank_data[bank_sel] * ts[ctl.tap_col];
    active = scf_pkg::KS_W'(cell_row) < ctl.ksize;
  end

  // Tap sums of this kernel row.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scf_pkg::MAX_KERNEL; i++) ts[i] <= '0;
    end else if (ts_wr.en && ts_wr.row == cell_row) begin
      ts[ts_wr.col] <= ts_wr.value;
    end
  end

  // Row accumulator.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.mac_en && active) begin
      acc <= acc + scf_pkg::ROW_ACC_W'(product);
    end else if (ctl.shift) begin
      acc <= acc_in;
    end
  end

  assign acc_out = acc;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for strided_conv2d_filter_sum: random weights, frames and settings.
// Depends on scf_pkg and the strided_conv2d_filter_sum RTL; predicts every result itself.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic signed [scf_pkg::SUM_W-1:0] conv_sum;
    logic [scf_pkg::OUT_POS_W-1:0]    out_row;
    logic [scf_pkg::OUT_POS_W-1:0]    out_col;
    logic                             frame_end;
  } conv_result_t;

  // Holds a predictor of the block and the queue of expected results.
  class conv_scoreboard;
    logic [2:0] ksize_reg, stride_reg;
    logic [3:0] fcount_reg;
    logic [6:0] width_reg, height_reg;
    logic signed [15:0] weights [scf_pkg::MAX_FILTERS][scf_pkg::TAPS];
    int tap_total [scf_pkg::TAPS];
    logic signed [15:0] lines [scf_pkg::MAX_KERNEL][scf_pkg::MAX_WIDTH];
    int pos_row, pos_col;
    conv_result_t expected_q [$];
    int errors, checked, frames_done;

    function void reset_state();
      ksize_reg = 3; stride_reg = 1; fcount_reg = 1;
      width_reg = 28; height_reg = 28;
      foreach (weights[f, t]) weights[f][t] = '0;
      foreach (tap_total[t]) tap_total[t] = 0;
      pos_row = 0; pos_col = 0;
      expected_q.delete();
      errors = 0; checked = 0; frames_done = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function void refresh_tap(int t);
      int n;
      n = clip(fcount_reg, 0, scf_pkg::MAX_FILTERS);
      tap_total[t] = 0;
      for (int f = 0; f < n; f++) tap_total[t] += weights[f][t];
    endfunction

    function void set_reg(logic [scf_pkg::CFG_IDX_W-1:0] idx,
                          logic [scf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        scf_pkg::REG_KERNEL_SIZE: ksize_reg = data[2:0];
        scf_pkg::REG_STRIDE_STEP: stride_reg = data[2:0];
        scf_pkg::REG_FILTER_COUNT: begin
          fcount_reg = data[3:0];
          for (int t = 0; t < scf_pkg::TAPS; t++) refresh_tap(t);
        end
        scf_pkg::REG_IMAGE_WIDTH: width_reg = data;
        scf_pkg::REG_IMAGE_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int eff_width();
      return clip(width_reg, 1, scf_pkg::MAX_WIDTH);
    endfunction

    function int eff_height();
      return clip(height_reg, 1, scf_pkg::MAX_HEIGHT);
    endfunction

    // Notes one accepted input word and queues the result it causes, if any.
    function void note_input(logic op, logic [2:0] fidx, logic [2:0] trow, logic [2:0] tcol,
                             logic signed [15:0] value);
      int k, s, w, h, r, c, top, left, lastr, lastc;
      longint acc;
      conv_result_t res;
      if (op == scf_pkg::OP_LOAD) begin
        if (trow < scf_pkg::MAX_KERNEL && tcol < scf_pkg::MAX_KERNEL) begin
          weights[fidx][trow*scf_pkg::MAX_KERNEL + tcol] = value;
          refresh_tap(trow*scf_pkg::MAX_KERNEL + tcol);
        end
        return;
      end
      k = clip(ksize_reg, 1, scf_pkg::MAX_KERNEL);
      s = clip(stride_reg, 1, scf_pkg::MAX_STRIDE);
      w = eff_width();
      h = eff_height();
      r = pos_row;
      c = pos_col;
      if (r < h && c < w) begin
        lines[r % scf_pkg::MAX_KERNEL][c] = value;
        if (r + 1 >= k && c + 1 >= k) begin
          top = r + 1 - k;
          left = c + 1 - k;
          if (top % s == 0 && left % s == 0) begin
            acc = 0;
            lastr = ((h - k) / s) * s + k - 1;
            lastc = ((w - k) / s) * s + k - 1;
            for (int u = 0; u < k; u++)
              for (int v = 0; v < k; v++)
                acc += longint'(lines[(top + u) % scf_pkg::MAX_KERNEL][left + v]) *
                       longint'(tap_total[u*scf_pkg::MAX_KERNEL + v]);
            if (acc > 64'sd549755813887) acc = 64'sd549755813887;
            if (acc < -64'sd549755813888) acc = -64'sd549755813888;
            res.conv_sum = acc[scf_pkg::SUM_W-1:0];
            res.out_row = scf_pkg::OUT_POS_W'(top / s);
            res.out_col = scf_pkg::OUT_POS_W'(left / s);
            res.frame_end = (r == lastr && c == lastc);
            if (res.frame_end) frames_done++;
            expected_q.push_back(res);
          end
        end
      end
      // Raster position advance, wrapping at the current frame size.
      if (c + 1 >= w) begin
        pos_col = 0;
        pos_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        pos_col = c + 1;
        if (r >= h) pos_row = 0;
      end
    endfunction

    // Compares one accepted result word with the oldest expected one.
    function void check_result(conv_result_t got);
      conv_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result sum=%0d row=%0d col=%0d", $time,
                 got.conv_sum, got.out_row, got.out_col);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (got.conv_sum !== exp_res.conv_sum) begin
        $display("%0t: conv_sum expected %0d actual %0d", $time, exp_res.conv_sum, got.conv_sum);
        errors++;
      end
      if (got.out_row !== exp_res.out_row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, exp_res.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== exp_res.out_col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, exp_res.out_col, got.out_col);
        errors++;
      end
      if (got.frame_end !== exp_res.frame_end) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, exp_res.frame_end,
                 got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = scf_pkg::OP_LOAD;
  logic [2:0] filter_index = '0, tap_row = '0, tap_col = '0;
  logic signed [scf_pkg::SAMPLE_W-1:0] sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [scf_pkg::SUM_W-1:0] conv_sum;
  logic [scf_pkg::OUT_POS_W-1:0] out_row, out_col;
  logic frame_end;

  conv_scoreboard sb;
  int cycle_no = 0;
  int words_sent = 0;
  int settings_used = 0;

  strided_conv2d_filter_sum u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Both sides run without gaps in this window.
  function automatic bit busy_window();
    return cycle_no >= 6000 && cycle_no < 9000;
  endfunction

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (cycle_no == 3000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= busy_window() || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    conv_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.conv_sum = conv_sum;
      got.out_row = out_row;
      got.out_col = out_col;
      got.frame_end = frame_end;
      sb.check_result(got);
    end
  end

  // Offers one word and returns once it is accepted.
  task automatic send_word(logic op, logic [2:0] fidx, logic [2:0] trow, logic [2:0] tcol,
                           logic signed [15:0] value);
    if (!busy_window() && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    filter_index <= fidx;
    tap_row <= trow;
    tap_col <= tcol;
    sample_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, fidx, trow, tcol, value);
    words_sent++;
  endtask

  task automatic load_random_weight();
    send_word(scf_pkg::OP_LOAD, 3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  task automatic send_pixel(logic signed [15:0] value);
    send_word(scf_pkg::OP_PIXEL, 3'($urandom), 3'($urandom), 3'($urandom), value);
  endtask

  // Drains all results, lets the block settle, then writes all five registers.
  task automatic write_settings(int ks, int st, int fc, int w, int h);
    int vals [5];
    vals = '{ks, st, fc, w, h};
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= scf_pkg::CFG_IDX_W'(i);
      cfg_data <= scf_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(scf_pkg::CFG_IDX_W'(i), scf_pkg::CFG_DATA_W'(vals[i]));
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // One full frame of random pixels with weight loads mixed in.
  task automatic send_frame();
    int n;
    n = sb.eff_width() * sb.eff_height();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) load_random_weight();
      send_pixel(16'($urandom));
    end
  endtask

  initial begin
    int mode, w, h;
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme weights, ignored loads and an extreme-valued 3x3 frame.
    write_settings(3, 1, 8, 3, 3);
    send_word(scf_pkg::OP_LOAD, 3'd0, 3'd0, 3'd0, 16'sh7fff);
    send_word(scf_pkg::OP_LOAD, 3'd7, 3'd2, 3'd2, -16'sd32768);
    send_word(scf_pkg::OP_LOAD, 3'd3, 3'd1, 3'd1, 16'sh7fff);
    send_word(scf_pkg::OP_LOAD, 3'd5, 3'd6, 3'd6, 16'sh0001);
    send_word(scf_pkg::OP_LOAD, 3'd2, 3'd7, 3'd0, 16'sh1234);
    send_word(scf_pkg::OP_LOAD, 3'd2, 3'd0, 3'd7, -16'sd1);
    send_word(scf_pkg::OP_LOAD, 3'd1, 3'd0, 3'd2, -16'sd32768);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? -16'sd32768 : 16'sh7fff);
    // Kernel larger than the image: no result.
    write_settings(7, 4, 0, 2, 3);
    for (int i = 0; i < 6; i++) send_pixel(16'($urandom));
    // Zero registers count as one; out-of-range ones saturate.
    write_settings(0, 0, 15, 0, 0);
    send_pixel(16'sh7fff);
    send_pixel(-16'sd32768);

    // Random settings, each run over whole frames.
    while (words_sent < 1750) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        w = $urandom_range(64, 127);
        h = $urandom_range(0, 6);
      end else if (mode == 1) begin
        w = $urandom_range(0, 4);
        h = $urandom_range(64, 127);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 12);
      end
      write_settings($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15), w, h);
      repeat ($urandom_range(0, 6)) load_random_weight();
      repeat ($urandom_range(1, 3)) send_frame();
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d words over %0d register settings; %0d results checked, %0d frames.",
             words_sent, settings_used, sb.checked, sb.frames_done);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> strided_conv2d_filter_sum.f
rtl/scf_pkg.sv
rtl/scf_divider.sv
rtl/scf_weight.sv
rtl/scf_cell.sv
rtl/strided_conv2d_filter_sum.sv
verif/testbench.sv
